// ===== rtl/pbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsm_pkg: shared types and constants for the pedal/brake safety monitor
// Register map, fault flag positions and the fixed torque scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pbsm_pkg;

  // configuration port
  localparam int unsigned CFG_W  = 10;  // widest register
  localparam int unsigned TICK_W = 8;   // persist_ticks width
  localparam int unsigned IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    CFG_TEST_MODE        = 3'd0,
    CFG_VOLT_MIN         = 3'd1,
    CFG_VOLT_MAX         = 3'd2,
    CFG_BRAKE_THRESHOLD  = 3'd3,
    CFG_MISMATCH_LIMIT   = 3'd4,
    CFG_PERSIST_TICKS    = 3'd5,
    CFG_OVERLAP_THROTTLE = 3'd6,
    CFG_RELEASE_THROTTLE = 3'd7
  } cfg_reg_e;

  // register reset values
  localparam logic              RST_TEST_MODE        = 1'b1;
  localparam logic [CFG_W-1:0]  RST_VOLT_MIN         = 10'd102;
  localparam logic [CFG_W-1:0]  RST_VOLT_MAX         = 10'd921;
  localparam logic [CFG_W-1:0]  RST_BRAKE_THRESHOLD  = 10'd25;
  localparam logic [CFG_W-1:0]  RST_MISMATCH_LIMIT   = 10'd102;
  localparam logic [TICK_W-1:0] RST_PERSIST_TICKS    = 8'd10;
  localparam logic [CFG_W-1:0]  RST_OVERLAP_THROTTLE = 10'd255;
  localparam logic [CFG_W-1:0]  RST_RELEASE_THROTTLE = 10'd52;

  // fault latch bits
  localparam int unsigned FLAG_W         = 6;
  localparam int unsigned FLAG_PEDAL_MIS = 0;
  localparam int unsigned FLAG_OVERLAP   = 1;
  localparam int unsigned FLAG_BRAKE_MIS = 2;
  localparam int unsigned FLAG_PEDAL_RNG = 3;
  localparam int unsigned FLAG_BRAKE_RNG = 4;
  localparam int unsigned FLAG_OVERTEMP  = 5;

  // torque scaling: avg -> speed 0..SPEED_FULL -> command 0..CMD_FULL
  localparam int unsigned SPEED_W     = 13;
  localparam int unsigned CMD_W       = 15;
  localparam int unsigned SPEED_FULL  = 5500;
  localparam int unsigned SPEED_FLOOR = 30;
  localparam int unsigned CMD_FULL    = 32767;

  // speed * CMD_FULL fits in PROD_W bits; reciprocal of SPEED_FULL at that shift
  localparam int unsigned PROD_W      = SPEED_W + CMD_W;
  localparam int unsigned CMD_RECIP   = (32'd1 << PROD_W) / SPEED_FULL;
  localparam int unsigned CMD_RECIP_W = 16;

endpackage

`default_nettype wire

// ===== rtl/pbsm_if.sv =====
// ----------------------------------------------------------------------------
// pbsm_if: request and result channels of the pedal/brake safety monitor
// Valid/ready handshake; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbsm_in_if #(
  parameter int unsigned ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [ADC_BITS-1:0] pedal_a;
  logic [ADC_BITS-1:0] pedal_b;
  logic [ADC_BITS-1:0] brake_a;
  logic [ADC_BITS-1:0] brake_b;
  logic                bms_fault;
  logic                imd_fault;
  logic                bspd_fault;
  logic                link_timeout;
  logic                over_temp_event;

  modport source (
    output valid, req_type, pedal_a, pedal_b, brake_a, brake_b,
           bms_fault, imd_fault, bspd_fault, link_timeout, over_temp_event,
    input  ready
  );
  modport sink (
    input  valid, req_type, pedal_a, pedal_b, brake_a, brake_b,
           bms_fault, imd_fault, bspd_fault, link_timeout, over_temp_event,
    output ready
  );
endinterface

interface pbsm_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] torque_cmd;
  logic        fault_active;
  logic        brake_on;
  logic        brake_light_send;
  logic [5:0]  fault_flags;
  logic        reset_accepted;

  modport source (
    output valid, torque_cmd, fault_active, brake_on, brake_light_send,
           fault_flags, reset_accepted,
    input  ready
  );
  modport sink (
    input  valid, torque_cmd, fault_active, brake_on, brake_light_send,
           fault_flags, reset_accepted,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/pedal_brake_safety_monitor.sv =====
// ----------------------------------------------------------------------------
// pedal_brake_safety_monitor: accelerator pedal / brake plausibility monitor
// Range, mismatch and overlap fault latches with torque command output.
// ----------------------------------------------------------------------------
// One request per clock is taken unless the result side stalls; one result
// comes out per request, in order. A request passes four stages of the torque
// scaling pipeline (two constant multiplies, each a reciprocal divide with a
// one-step correction), then the result register, where fault latches,
// mismatch counters and the brake light state are updated. The whole pipeline
// advances whenever the result register is empty or being read, so ready
// follows the result side directly. The user must write registers through the
// plain write port only while no request is in flight; it is not enforced.
`default_nettype none

module pedal_brake_safety_monitor #(
  parameter int unsigned ADC_BITS   = 10,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pbsm_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [pbsm_pkg::CFG_W-1:0]  cfg_data_i,
  pbsm_in_if.sink                     in_i,
  pbsm_out_if.source                  out_o
);
  import pbsm_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned CW    = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;
  localparam int unsigned KW    = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;

  typedef struct packed {
    logic                req_type;
    logic [ADC_BITS-1:0] pedal_a;
    logic [ADC_BITS-1:0] pedal_b;
    logic [ADC_BITS-1:0] brake_a;
    logic [ADC_BITS-1:0] brake_b;
    logic                ext_fault;
    logic                over_temp;
  } item_t;

  // configuration
  logic              test_mode_q;
  logic [CFG_W-1:0]  volt_min_q, volt_max_q, brake_thr_q, mis_limit_q;
  logic [CFG_W-1:0]  overlap_thr_q, release_thr_q;
  logic [TICK_W-1:0] persist_q;

  // pipeline
  logic              en;
  item_t             in_item;
  item_t             stage_q [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  item_t             cur;
  logic [CMD_W-1:0]  torque_scaled;

  // state
  logic [FLAG_W-1:0]     latch_d, latch_q;
  logic [COUNT_BITS-1:0] pcnt_d, pcnt_q, bcnt_d, bcnt_q;
  logic                  light_d, light_q;

  // decision outputs
  logic [CMD_W-1:0]  torque_d, torque_q;
  logic              active_d, active_q;
  logic              brake_d, brake_q;
  logic              send_d, send_q;
  logic              accepted_d, accepted_q;
  logic              out_valid_q;

  // compares on the item at the last stage
  logic [ADC_BITS-1:0] pdiff, bdiff;
  logic [ADC_BITS:0]   bsum;
  logic                released, pa_rng, pb_rng, ba_rng, bb_rng;
  logic                pmis, bmis, brake_avg_on, over_thr, ba_over;

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_mode_q   <= RST_TEST_MODE;
      volt_min_q    <= RST_VOLT_MIN;
      volt_max_q    <= RST_VOLT_MAX;
      brake_thr_q   <= RST_BRAKE_THRESHOLD;
      mis_limit_q   <= RST_MISMATCH_LIMIT;
      persist_q     <= RST_PERSIST_TICKS;
      overlap_thr_q <= RST_OVERLAP_THROTTLE;
      release_thr_q <= RST_RELEASE_THROTTLE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TEST_MODE:        test_mode_q   <= cfg_data_i[0];
        CFG_VOLT_MIN:         volt_min_q    <= cfg_data_i;
        CFG_VOLT_MAX:         volt_max_q    <= cfg_data_i;
        CFG_BRAKE_THRESHOLD:  brake_thr_q   <= cfg_data_i;
        CFG_MISMATCH_LIMIT:   mis_limit_q   <= cfg_data_i;
        CFG_PERSIST_TICKS:    persist_q     <= cfg_data_i[TICK_W-1:0];
        CFG_OVERLAP_THROTTLE: overlap_thr_q <= cfg_data_i;
        CFG_RELEASE_THROTTLE: release_thr_q <= cfg_data_i;
      endcase
    end
  end

  // pipeline advance: result register free or being taken
  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign in_item.req_type  = in_i.req_type;
  assign in_item.pedal_a   = in_i.pedal_a;
  assign in_item.pedal_b   = in_i.pedal_b;
  assign in_item.brake_a   = in_i.brake_a;
  assign in_item.brake_b   = in_i.brake_b;
  assign in_item.ext_fault = in_i.bms_fault | in_i.imd_fault | in_i.bspd_fault |
                             in_i.link_timeout;
  assign in_item.over_temp = in_i.over_temp_event;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[DEPTH-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stage_q[0] <= in_item;
      for (int i = 1; i < DEPTH; i++) begin
        stage_q[i] <= stage_q[i-1];
      end
    end
  end

  assign cur = stage_q[DEPTH-1];

  // torque scaling, aligned with the last stage
  pbsm_scale #(
    .ADC_BITS (ADC_BITS)
  ) u_scale (
    .clk_i     (clk_i),
    .en_i      (en),
    .pedal_a_i (in_i.pedal_a),
    .pedal_b_i (in_i.pedal_b),
    .torque_o  (torque_scaled)
  );

  // sensor checks
  assign pdiff = (cur.pedal_a > cur.pedal_b) ? cur.pedal_a - cur.pedal_b
                                             : cur.pedal_b - cur.pedal_a;
  assign bdiff = (cur.brake_a > cur.brake_b) ? cur.brake_a - cur.brake_b
                                             : cur.brake_b - cur.brake_a;
  assign bsum  = {1'b0, cur.brake_a} + {1'b0, cur.brake_b};

  assign released  = (CW'(cur.pedal_a) < CW'(release_thr_q)) &&
                     (CW'(cur.pedal_b) < CW'(release_thr_q));
  assign pa_rng    = (CW'(cur.pedal_a) < CW'(volt_min_q)) ||
                     (CW'(cur.pedal_a) > CW'(volt_max_q));
  assign pb_rng    = (CW'(cur.pedal_b) < CW'(volt_min_q)) ||
                     (CW'(cur.pedal_b) > CW'(volt_max_q));
  assign ba_rng    = (CW'(cur.brake_a) < CW'(volt_min_q)) ||
                     (CW'(cur.brake_a) > CW'(volt_max_q));
  assign bb_rng    = (CW'(cur.brake_b) < CW'(volt_min_q)) ||
                     (CW'(cur.brake_b) > CW'(volt_max_q));
  assign pmis      = CW'(pdiff) > CW'(mis_limit_q);
  assign bmis      = CW'(bdiff) > CW'(mis_limit_q);
  assign brake_avg_on = CW'(bsum[ADC_BITS:1]) > CW'(brake_thr_q);
  assign ba_over   = CW'(cur.brake_a) > CW'(brake_thr_q);
  assign over_thr  = (CW'(cur.pedal_a) > CW'(overlap_thr_q)) ||
                     (CW'(cur.pedal_b) > CW'(overlap_thr_q));

  // fault latch, counter and result logic
  always_comb begin
    latch_d    = latch_q;
    pcnt_d     = pcnt_q;
    bcnt_d     = bcnt_q;
    light_d    = light_q;
    torque_d   = '0;
    brake_d    = 1'b0;
    send_d     = 1'b0;
    accepted_d = 1'b0;

    if (cur.req_type) begin
      // reset request: clear only when safe; overtemp applied after the clear
      if (released && !ba_over && !cur.ext_fault) begin
        latch_d    = '0;
        accepted_d = 1'b1;
      end
      if (cur.over_temp) begin
        latch_d[FLAG_OVERTEMP] = 1'b1;
      end
    end else begin
      if (cur.over_temp) begin
        latch_d[FLAG_OVERTEMP] = 1'b1;
      end
      if (!test_mode_q) begin
        if (pa_rng || pb_rng) begin
          latch_d[FLAG_PEDAL_RNG] = 1'b1;
        end
        if (ba_rng || bb_rng) begin
          latch_d[FLAG_BRAKE_RNG] = 1'b1;
        end
        // persistence counters, saturating
        if (!bmis) begin
          bcnt_d = '0;
        end else if (bcnt_q != '1) begin
          bcnt_d = bcnt_q + COUNT_BITS'(1);
        end
        if (bmis && (KW'(bcnt_d) > KW'(persist_q))) begin
          latch_d[FLAG_BRAKE_MIS] = 1'b1;
        end
        if (!pmis) begin
          pcnt_d = '0;
        end else if (pcnt_q != '1) begin
          pcnt_d = pcnt_q + COUNT_BITS'(1);
        end
        if (pmis && (KW'(pcnt_d) > KW'(persist_q))) begin
          latch_d[FLAG_PEDAL_MIS] = 1'b1;
        end
        brake_d = brake_avg_on;
        if (brake_avg_on && over_thr) begin
          latch_d[FLAG_OVERLAP] = 1'b1;
        end
        if (released) begin
          latch_d[FLAG_OVERLAP] = 1'b0;
        end
      end
      if ((latch_d != '0) || cur.ext_fault) begin
        send_d = !test_mode_q;
      end else begin
        torque_d = brake_d ? '0 : torque_scaled;
        if (!test_mode_q && (brake_d != light_q)) begin
          send_d  = 1'b1;
          light_d = brake_d;
        end
      end
    end
  end

  assign active_d = (latch_d != '0) || cur.ext_fault;

  // state update when the last stage moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      pcnt_q  <= '0;
      bcnt_q  <= '0;
      light_q <= 1'b0;
    end else if (en && valid_q[DEPTH-1]) begin
      latch_q <= latch_d;
      pcnt_q  <= pcnt_d;
      bcnt_q  <= bcnt_d;
      light_q <= light_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      torque_q   <= torque_d;
      active_q   <= active_d;
      brake_q    <= brake_d;
      send_q     <= send_d;
      accepted_q <= accepted_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.torque_cmd       = torque_q;
  assign out_o.fault_active     = active_q;
  assign out_o.brake_on         = brake_q;
  assign out_o.brake_light_send = send_q;
  assign out_o.fault_flags      = latch_q;
  assign out_o.reset_accepted   = accepted_q;

endmodule

`default_nettype wire

// ===== rtl/pbsm_scale.sv =====
// ----------------------------------------------------------------------------
// pbsm_scale: pedal average to torque command, four register stages
// speed = avg * 5500 / full_scale, floored below 30, then
// cmd = speed * 32767 / 5500; both divides by reciprocal plus one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsm_scale #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ADC_BITS-1:0]       pedal_a_i,
  input  logic [ADC_BITS-1:0]       pedal_b_i,
  output logic [pbsm_pkg::CMD_W-1:0] torque_o
);
  import pbsm_pkg::*;

  // avg * SPEED_FULL < 2^XW; divisor is the ADC full scale 2^N - 1
  localparam int unsigned           XW   = ADC_BITS + SPEED_W;
  localparam longint unsigned       DIV  = (64'd1 << ADC_BITS) - 64'd1;
  localparam longint unsigned       RCP  = (64'd1 << XW) / DIV;
  localparam int unsigned           RW   = $clog2(RCP + 64'd1);
  localparam int unsigned           P1W  = XW + RW;
  localparam int unsigned           P2W  = PROD_W + CMD_RECIP_W;

  logic [ADC_BITS:0]     pedal_sum;
  logic [ADC_BITS-1:0]   pedal_avg;
  logic [XW-1:0]         x1_d, x1_q;
  logic [P1W-1:0]        p1;
  logic [SPEED_W-1:0]    q1_d, q1_q;
  logic [XW-1:0]         x2_q;
  logic [XW:0]           rem1;
  logic [SPEED_W-1:0]    speed;
  logic [SPEED_W-1:0]    speed_fl;
  logic [PROD_W-1:0]     y1_d, y1_q;
  logic [P2W-1:0]        p2;
  logic [CMD_W-1:0]      q2_d, q2_q;
  logic [PROD_W-1:0]     y2_q;
  logic [PROD_W-1:0]     rem2;

  // stage 1: average and scale up
  assign pedal_sum = {1'b0, pedal_a_i} + {1'b0, pedal_b_i};
  assign pedal_avg = pedal_sum[ADC_BITS:1];
  assign x1_d      = XW'(pedal_avg) * XW'(SPEED_FULL);

  // stage 2: quotient estimate, low by at most one
  assign p1   = P1W'(x1_q) * P1W'(RCP);
  assign q1_d = p1[XW +: SPEED_W];

  // stage 3: correct (q * (2^N - 1) is a shift and subtract), floor, rescale
  assign rem1     = (XW+1)'(x2_q) - ((XW+1)'(q1_q) << ADC_BITS) + (XW+1)'(q1_q);
  assign speed    = (rem1 >= (XW+1)'(DIV)) ? q1_q + SPEED_W'(1) : q1_q;
  assign speed_fl = (speed < SPEED_W'(SPEED_FLOOR)) ? '0 : speed;
  assign y1_d     = PROD_W'(speed_fl) * PROD_W'(CMD_FULL);

  // stage 4: quotient estimate for the second divide
  assign p2   = P2W'(y1_q) * P2W'(CMD_RECIP);
  assign q2_d = p2[PROD_W +: CMD_W];

  // output: final correction
  assign rem2     = y2_q - PROD_W'(q2_q) * PROD_W'(SPEED_FULL);
  assign torque_o = (rem2 >= PROD_W'(SPEED_FULL)) ? q2_q + CMD_W'(1) : q2_q;

  // pipeline registers, all advance together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= x1_d;
      q1_q <= q1_d;
      x2_q <= x1_q;
      y1_q <= y1_d;
      q2_q <= q2_d;
      y2_q <= y1_q;
    end
  end

endmodule

`default_nettype wire
